// ----- hw/rtl/mrbc_pkg.sv -----
// Shared types, constants and the log table of the multiresolution bitmap counter.
package mrbc_pkg;

   localparam int COMPONENT_BITS = 64;    // power of two
   localparam int COMPONENTS     = 8;
   localparam int LAST_BITS      = 128;   // power of two
   localparam int LOG_FRAC_BITS  = 16;

   localparam int NUM_ROWS  = COMPONENTS - 1 + LAST_BITS / COMPONENT_BITS;
   localparam int ROW_W     = $clog2(NUM_ROWS);
   localparam int BIT_W     = $clog2(COMPONENT_BITS);
   localparam int LP_W      = $clog2(LAST_BITS);
   localparam int LN_MAX    = (LAST_BITS > COMPONENT_BITS) ? LAST_BITS : COMPONENT_BITS;
   localparam int CNT_W     = $clog2(LN_MAX + 1);
   localparam int LN_W      = CNT_W + LOG_FRAC_BITS;
   localparam int TERM_W    = LN_W + CNT_W;
   localparam int M_W       = TERM_W + $clog2(COMPONENTS);
   localparam int SH_W      = $clog2(COMPONENTS);
   localparam int THR_W     = 9;
   localparam int EST_W     = 24;
   localparam int CMP_W     = (CNT_W > THR_W) ? CNT_W : THR_W;
   localparam int Q_DEPTH   = 2;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(60);
   localparam logic [1:0] CMD_INSERT   = 2'd0;
   localparam logic [1:0] CMD_ESTIMATE = 2'd1;
   localparam logic [1:0] CMD_CLEAR    = 2'd2;

   typedef enum logic [1:0] {
      OP_INSERT,
      OP_ESTIMATE,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [ROW_W-1:0] row;
      logic [BIT_W-1:0] bitpos;
   } q_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_WRITE,
      ST_EST_POP,
      ST_EST_ACC,
      ST_EST_LAST,
      ST_EST_DONE
   } back_state_type;

   typedef logic [LN_MAX:0][LN_W-1:0] ln_table_type;

   // ln(n) in Q.LOG_FRAC_BITS through log2 by repeated squaring; ln(0) reads as 0
   function automatic logic [63:0] ln_fixed(input int n);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] l2;
      logic [63:0] prod;
      int k;
      r = 64'd0;
      if (n == 0) begin
         return 64'd0;
      end
      k = 0;
      while (k < 31 && (n >> (k + 1)) != 0) begin
         k++;
      end
      x = 64'(n) << (30 - k);
      for (int i = 0; i < 30; i++) begin
         x = (x * x) >> 30;
         if (x >= (64'd2 << 30)) begin
            x = x >> 1;
            r = r | (64'd1 << (29 - i));
         end
      end
      l2 = (64'(k) << 30) + r;
      prod = l2 * 64'd186065280;
      return (prod + (64'd1 << (57 - LOG_FRAC_BITS))) >> (58 - LOG_FRAC_BITS);
   endfunction

   function automatic ln_table_type build_ln_table();
      ln_table_type t;
      for (int i = 0; i <= LN_MAX; i++) begin
         t[i] = LN_W'(ln_fixed(i));
      end
      return t;
   endfunction

   localparam ln_table_type LN_TABLE = build_ln_table();

   function automatic logic [CNT_W-1:0] popcount(input logic [COMPONENT_BITS-1:0] w);
      logic [CNT_W-1:0] c;
      c = '0;
      for (int i = 0; i < COMPONENT_BITS; i++) begin
         c = c + CNT_W'(w[i]);
      end
      return c;
   endfunction

endpackage

// ----- hw/rtl/multiresolution_bitmap_counter_unit.sv -----
// An insert reads its bitmap row and writes it back; a clear takes effect as it leaves the queue.
// The back end takes no new request until the read-modify-write of the bitmap row is done.
// An estimate walks every bitmap row through one popcount and log-table unit.
// A two-entry request queue lets requests in while the back end works.
// Reset (synchronous): bitmap reads as all zeros, queue empty, threshold 60.
// Clear and reset drop all per-row valid bits together; no clearing pass.
module multiresolution_bitmap_counter_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_cmd,
   input  logic [31:0]                req_key,
   input  logic [2:0]                 req_level,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [mrbc_pkg::EST_W-1:0] rsp_estimate_value,
   output logic                       rsp_saturated,
   input  logic                       csr_wr_en,
   input  logic [mrbc_pkg::THR_W-1:0] csr_wr_data
);
   import mrbc_pkg::*;

   logic [THR_W-1:0] threshold_ff;
   logic             q_full;
   logic             q_push;
   logic             q_pop;
   logic             q_not_empty;
   q_entry_type      q_in_entry;
   q_entry_type      q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THR_RESET;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   mrbc_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .req_key   (req_key),
      .req_level (req_level),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_in_entry)
   );

   mrbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in_entry),
      .pop        (q_pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   mrbc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .threshold          (threshold_ff),
      .q_not_empty        (q_not_empty),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_estimate_value (rsp_estimate_value),
      .rsp_saturated      (rsp_saturated)
   );

   a_sat_clamps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_estimate_value == {EST_W{1'b1}})
      else $error("saturated estimate not clamped");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready && !q_not_empty)
      else $error("state not cleared by reset");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty)
      else $error("pop from empty request queue");

endmodule

// ----- hw/rtl/mrbc_front.sv -----
// Request front end: decodes the command and the bitmap address of an insert.
module mrbc_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_cmd,
   input  logic [31:0]          req_key,
   input  logic [2:0]           req_level,
   input  logic                 q_full,
   output logic                 q_push,
   output mrbc_pkg::q_entry_type q_entry
);
   import mrbc_pkg::*;

   logic [63:0]      prod_mid;
   logic [63:0]      prod_last;
   logic [LP_W-1:0]  p_last;
   logic             use_entry;

   assign req_ready = !q_full;
   assign prod_mid  = 64'(req_key) * 64'(COMPONENT_BITS);
   assign prod_last = 64'(req_key) * 64'(LAST_BITS);
   assign p_last    = prod_last[32 +: LP_W];

   always_comb begin
      q_entry.op     = OP_INSERT;
      q_entry.row    = '0;
      q_entry.bitpos = '0;
      use_entry      = 1'b1;
      case (req_cmd)
         CMD_INSERT: begin
            q_entry.op = OP_INSERT;
            if (32'(req_level) < 32'(COMPONENTS - 1)) begin
               q_entry.row    = ROW_W'(req_level);
               q_entry.bitpos = prod_mid[32 +: BIT_W];
            end else begin
               q_entry.row    = ROW_W'(COMPONENTS - 1) + ROW_W'(p_last >> BIT_W);
               q_entry.bitpos = p_last[BIT_W-1:0];
            end
         end
         CMD_ESTIMATE: q_entry.op = OP_ESTIMATE;
         CMD_CLEAR:    q_entry.op = OP_CLEAR;
         default:      use_entry  = 1'b0;   // drop unused command
      endcase
   end

   assign q_push = req_valid && !q_full && use_entry;

endmodule

// ----- hw/rtl/mrbc_queue.sv -----
// Two-entry queue between the front end and the execution back end.
module mrbc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mrbc_pkg::q_entry_type push_entry,
   input  logic                  pop,
   output logic                  full,
   output logic                  not_empty,
   output mrbc_pkg::q_entry_type head
);
   import mrbc_pkg::*;

   q_entry_type      slot_ff [Q_DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full      = (count_ff == 2'(Q_DEPTH));
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- hw/rtl/mrbc_back.sv -----
// Execution back end: bitmap memory, insert, clear and the estimate sequencer.
module mrbc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [mrbc_pkg::THR_W-1:0]   threshold,
   input  logic                         q_not_empty,
   input  mrbc_pkg::q_entry_type        q_head,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [mrbc_pkg::EST_W-1:0]   rsp_estimate_value,
   output logic                         rsp_saturated
);
   import mrbc_pkg::*;

   localparam int SUM_W = M_W + COMPONENTS;

   back_state_type state_ff, state_in;

   logic [COMPONENT_BITS-1:0] mem [NUM_ROWS];
   logic [NUM_ROWS-1:0]       row_valid_ff;
   logic [COMPONENT_BITS-1:0] rdata_ff;
   logic                      rvalid_ff;
   logic [COMPONENT_BITS-1:0] rword;

   logic [ROW_W-1:0]  rd_addr;
   logic              mem_we;
   logic              clr_all;
   logic              rsp_load;

   logic [ROW_W-1:0]  ins_row_ff;
   logic [BIT_W-1:0]  ins_bit_ff;
   logic [ROW_W-1:0]  row_cnt_ff;
   logic [CNT_W-1:0]  pop_ff;
   logic [CNT_W-1:0]  last_ones_ff;
   logic [M_W-1:0]    m_ff;
   logic [SH_W-1:0]   shift_ff;

   logic              rsp_valid_ff;
   logic [EST_W-1:0]  rsp_value_ff;
   logic              rsp_sat_ff;

   logic              is_last_comp;
   logic              is_last_row;
   logic [CNT_W-1:0]  zeros_mid;
   logic              comp_full;
   logic [TERM_W-1:0] term_mid;
   logic [CNT_W-1:0]  last_ones_sum;
   logic [CNT_W-1:0]  zeros_last;
   logic [TERM_W-1:0] term_last;
   logic [SUM_W-1:0]  scaled;
   logic [SUM_W-1:0]  val;

   assign rword        = rvalid_ff ? rdata_ff : '0;
   assign is_last_comp = (32'(row_cnt_ff) >= 32'(COMPONENTS - 1));
   assign is_last_row  = (32'(row_cnt_ff) == 32'(NUM_ROWS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               case (q_head.op)
                  OP_INSERT:   state_in = ST_INS_WRITE;
                  OP_ESTIMATE: state_in = ST_EST_POP;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_INS_WRITE: state_in = ST_IDLE;
         ST_EST_POP:   state_in = ST_EST_ACC;
         ST_EST_ACC:   state_in = (is_last_comp && is_last_row) ? ST_EST_LAST : ST_EST_POP;
         ST_EST_LAST:  state_in = ST_EST_DONE;
         ST_EST_DONE:  state_in = rsp_load ? ST_IDLE : ST_EST_DONE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop    = 1'b0;
      rd_addr  = '0;
      mem_we   = 1'b0;
      clr_all  = 1'b0;
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            q_pop   = q_not_empty;
            rd_addr = (q_head.op == OP_INSERT) ? q_head.row : '0;
            clr_all = q_not_empty && (q_head.op == OP_CLEAR);
         end
         ST_INS_WRITE: mem_we   = 1'b1;
         ST_EST_ACC:   rd_addr  = is_last_row ? '0 : row_cnt_ff + ROW_W'(1);
         ST_EST_DONE:  rsp_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // bitmap memory; a row that is not valid reads as zero
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[ins_row_ff] <= rword | (COMPONENT_BITS'(1) << ins_bit_ff);
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || clr_all) begin
         row_valid_ff <= '0;
         rvalid_ff    <= 1'b0;
      end else begin
         if (mem_we) begin
            row_valid_ff[ins_row_ff] <= 1'b1;
         end
         rvalid_ff <= row_valid_ff[rd_addr];
      end
   end

   // per-component linear-counting terms
   always_comb begin
      zeros_mid     = CNT_W'(COMPONENT_BITS) - pop_ff;
      comp_full     = (zeros_mid == '0) || (CMP_W'(pop_ff) > CMP_W'(threshold));
      term_mid      = TERM_W'(COMPONENT_BITS) *
                      TERM_W'(LN_TABLE[COMPONENT_BITS] - LN_TABLE[zeros_mid]);
      last_ones_sum = last_ones_ff + pop_ff;
      zeros_last    = CNT_W'(LAST_BITS) - last_ones_ff;
      term_last     = TERM_W'(LAST_BITS) *
                      TERM_W'(LN_TABLE[LAST_BITS] - LN_TABLE[zeros_last]);
      scaled        = SUM_W'(m_ff) << shift_ff;
      val           = (scaled + SUM_W'(1 << (LOG_FRAC_BITS - 1))) >> LOG_FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            ins_row_ff   <= q_head.row;
            ins_bit_ff   <= q_head.bitpos;
            row_cnt_ff   <= '0;
            last_ones_ff <= '0;
            m_ff         <= '0;
            shift_ff     <= '0;
         end
         ST_EST_POP: pop_ff <= popcount(rword);
         ST_EST_ACC: begin
            row_cnt_ff <= row_cnt_ff + ROW_W'(1);
            if (is_last_comp) begin
               last_ones_ff <= last_ones_sum;
            end else if (comp_full) begin
               // restart the sum above a full component
               m_ff     <= '0;
               shift_ff <= SH_W'(row_cnt_ff) + SH_W'(1);
            end else begin
               m_ff <= m_ff + M_W'(term_mid);
            end
         end
         ST_EST_LAST: m_ff <= m_ff + M_W'(term_last);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (val > SUM_W'({EST_W{1'b1}})) begin
            rsp_value_ff <= {EST_W{1'b1}};
            rsp_sat_ff   <= 1'b1;
         end else begin
            rsp_value_ff <= val[EST_W-1:0];
            rsp_sat_ff   <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_estimate_value = rsp_value_ff;
   assign rsp_saturated      = rsp_sat_ff;

endmodule
